FILE: hdl/dsdd_pkg.sv
// Shared types, constants and helper functions for the dual stepper
// differential drive block. No dependencies.
package dsdd_pkg;

	localparam int PERIOD_BITS_DEF = 10;
	localparam int COUNT_BITS_DEF = 16;

	localparam int CFG_BITS = 10;
	localparam int SPEED_BITS = 8;
	localparam int DIR_BITS = 9;
	localparam int STEP_BITS = 16;
	localparam int COIL_BITS = 4;
	localparam int MAG_BITS = 7;
	localparam int FACT_BITS = 8;
	localparam int PROD_BITS = MAG_BITS + FACT_BITS;

	localparam int PCT_FULL = 100;
	localparam int MIN_PERIOD_RST = 5;
	localparam int MAX_PERIOD_RST = 50;

	// Division by 100 as a multiply by a rounded-up reciprocal and a shift.
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_BITS = 24;
	localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'(((1 << RECIP_SHIFT) + 99) / 100);

	localparam logic signed [SPEED_BITS-1:0] SPEED_HI = 8'sd100;
	localparam logic signed [SPEED_BITS-1:0] SPEED_LO = -8'sd100;
	localparam logic signed [DIR_BITS-1:0] DIR_FULL = 9'sd100;
	localparam logic signed [DIR_BITS-1:0] DIR_LO = -9'sd100;
	localparam logic signed [DIR_BITS-1:0] ROT_QUARTER = 9'sd90;
	localparam logic signed [DIR_BITS-1:0] ROT_HALF = 9'sd180;

	localparam logic REG_MIN_PERIOD = 1'b0;
	localparam logic REG_MAX_PERIOD = 1'b1;

	typedef enum logic [1:0] {
		CMD_DRIVE  = 2'd0,
		CMD_ROTATE = 2'd1,
		CMD_STOP   = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SPEED = 2'd1,
		ST_DIR   = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                         cmd;
		status_t                      status;
		logic [1:0]                   neg;
		logic [1:0][MAG_BITS-1:0]     mag;
		logic [STEP_BITS-1:0]         cnt;
	} item_t;

	function automatic logic [COIL_BITS-1:0] wave(input logic neg, input logic [1:0] k);
		logic [1:0] ph;
		logic [COIL_BITS-1:0] coils;
		ph = neg ? ~k : k;
		unique case (ph)
			2'd0: coils = 4'b1000;
			2'd1: coils = 4'b0010;
			2'd2: coils = 4'b0100;
			default: coils = 4'b0001;
		endcase
		return coils;
	endfunction

endpackage

FILE: hdl/dsdd_mix.sv
// Command check and speed mixing: validates a command and derives both motor
// speed magnitudes and signs over two pipeline stages. Uses dsdd_pkg.
module dsdd_mix
	import dsdd_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_s1,
	input  cmd_t                        cmd_s1,
	input  logic signed [SPEED_BITS-1:0] spd_s1,
	input  logic signed [DIR_BITS-1:0]  dir_s1,
	input  logic [STEP_BITS-1:0]        cnt_s1,
	output logic                        v_s3,
	output item_t                       item_s3
);

	logic is_drive, is_rot, spd_bad, dir_bad, rot_ok;
	logic [SPEED_BITS-1:0] spd_abs;
	logic [MAG_BITS-1:0] mag;
	logic signed [DIR_BITS-1:0] f_l_w, f_r_w;
	logic [1:0][FACT_BITS-1:0] fact;
	status_t st;
	item_t item_d;

	logic v_s2;
	item_t item_s2;
	logic [1:0][PROD_BITS-1:0] prod_s2;
	logic [1:0][PROD_BITS+RECIP_BITS-1:0] full;
	item_t item_q3;

	always_comb begin
		is_drive = (cmd_s1 == CMD_DRIVE);
		is_rot = (cmd_s1 == CMD_ROTATE);
		spd_bad = (spd_s1 > SPEED_HI) || (spd_s1 < SPEED_LO);
		dir_bad = (dir_s1 > DIR_FULL) || (dir_s1 < DIR_LO);
		rot_ok = (dir_s1 == ROT_QUARTER) || (dir_s1 == -ROT_QUARTER) ||
			(dir_s1 == ROT_HALF) || (dir_s1 == -ROT_HALF);
		priority if (!(is_drive || is_rot)) begin
			st = ST_OK;
		end else if (spd_bad) begin
			st = ST_SPEED;
		end else if (is_drive && dir_bad) begin
			st = ST_DIR;
		end else if (is_rot && !rot_ok) begin
			st = ST_DIR;
		end else begin
			st = ST_OK;
		end
		spd_abs = spd_s1[SPEED_BITS-1] ? (~spd_s1 + 1'b1) : spd_s1;
		mag = spd_abs[MAG_BITS-1:0];
		f_l_w = dir_s1 + DIR_FULL;
		f_r_w = DIR_FULL - dir_s1;
		fact[0] = (is_drive && dir_s1 < 0) ? f_l_w[FACT_BITS-1:0] : FACT_BITS'(PCT_FULL);
		fact[1] = (is_drive && dir_s1 > 0) ? f_r_w[FACT_BITS-1:0] : FACT_BITS'(PCT_FULL);
		item_d.cmd = cmd_s1;
		item_d.status = st;
		item_d.neg[0] = spd_s1[SPEED_BITS-1];
		item_d.neg[1] = spd_s1[SPEED_BITS-1] ^ is_rot;
		item_d.mag = '0;
		item_d.cnt = cnt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		item_q3 = item_s2;
		for (int m = 0; m < 2; m++) begin
			full[m] = {{RECIP_BITS{1'b0}}, prod_s2[m]} * {{PROD_BITS{1'b0}}, RECIP_MUL};
			item_q3.mag[m] = full[m][RECIP_SHIFT +: MAG_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= item_d;
			for (int m = 0; m < 2; m++) begin
				prod_s2[m] <= {{FACT_BITS{1'b0}}, mag} * {{MAG_BITS{1'b0}}, fact[m]};
			end
			item_s3 <= item_q3;
		end
	end

endmodule

FILE: hdl/dsdd_period.sv
// Step period calculation: maps each motor speed magnitude to a period in
// ticks between the configured minimum and maximum. Uses dsdd_pkg.
module dsdd_period
	import dsdd_pkg::*;
#(
	parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [PERIOD_BITS-1:0]      min_period,
	input  logic [PERIOD_BITS-1:0]      max_period,
	input  logic                        v_s3,
	input  item_t                       item_s3,
	output logic                        v_s5,
	output item_t                       item_s5,
	output logic [1:0][PERIOD_BITS-1:0] period_s5
);

	localparam int SPAN_PROD_BITS = PERIOD_BITS + MAG_BITS;
	localparam int FULL_BITS = SPAN_PROD_BITS + RECIP_BITS;

	logic [PERIOD_BITS-1:0] hi, span;
	logic [1:0][MAG_BITS-1:0] fact;
	logic [1:0][SPAN_PROD_BITS-1:0] prod_d;

	logic v_s4;
	item_t item_s4;
	logic [1:0][SPAN_PROD_BITS-1:0] prod_s4;
	logic [1:0][FULL_BITS-1:0] full;
	logic [1:0][PERIOD_BITS-1:0] p;

	always_comb begin
		hi = (max_period < min_period) ? min_period : max_period;
		span = hi - min_period;
		for (int m = 0; m < 2; m++) begin
			fact[m] = MAG_BITS'(PCT_FULL) - item_s3.mag[m];
			prod_d[m] = {{MAG_BITS{1'b0}}, span} * {{PERIOD_BITS{1'b0}}, fact[m]};
		end
	end

	always_comb begin
		for (int m = 0; m < 2; m++) begin
			full[m] = {{RECIP_BITS{1'b0}}, prod_s4[m]} * {{SPAN_PROD_BITS{1'b0}}, RECIP_MUL};
			p[m] = min_period + full[m][RECIP_SHIFT +: PERIOD_BITS];
			if (p[m] == '0) begin
				p[m] = PERIOD_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4 <= item_s3;
			prod_s4 <= prod_d;
			item_s5 <= item_s4;
			period_s5 <= p;
		end
	end

endmodule

FILE: hdl/dsdd_motion.sv
// Motion state and result register: applies commands and ticks to the motor
// counters and coil patterns and presents each result. Uses dsdd_pkg.
module dsdd_motion
	import dsdd_pkg::*;
#(
	parameter int PERIOD_BITS = PERIOD_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_s5,
	input  item_t                       item_s5,
	input  logic [1:0][PERIOD_BITS-1:0] period_s5,
	output logic                        res_valid,
	output logic [1:0]                  status,
	output logic [COIL_BITS-1:0]        coils_left,
	output logic [COIL_BITS-1:0]        coils_right,
	output logic                        running
);

	logic res_valid_q;
	status_t status_q;
	logic [1:0] moving_q, neg_q;
	logic [1:0][PERIOD_BITS-1:0] reload_q, countdown_q;
	logic [1:0][COUNT_BITS-1:0] steps_q;
	logic [1:0][COIL_BITS-1:0] coil_q;
	logic [COUNT_BITS-1:0] limit_q;
	logic active_q;

	logic [1:0] moving_d, neg_d, expired;
	logic [1:0][PERIOD_BITS-1:0] reload_d, countdown_d;
	logic [1:0][COUNT_BITS-1:0] steps_d;
	logic [1:0][COIL_BITS-1:0] coil_d;
	logic [COUNT_BITS-1:0] limit_d;
	logic active_d, finished;

	always_comb begin
		moving_d = moving_q;
		neg_d = neg_q;
		reload_d = reload_q;
		countdown_d = countdown_q;
		steps_d = steps_q;
		coil_d = coil_q;
		limit_d = limit_q;
		active_d = active_q;
		expired = '0;
		finished = 1'b0;
		unique case (item_s5.cmd)
			CMD_DRIVE, CMD_ROTATE: begin
				if (item_s5.status == ST_OK) begin
					for (int m = 0; m < 2; m++) begin
						moving_d[m] = (item_s5.mag[m] != '0);
						neg_d[m] = item_s5.neg[m];
						reload_d[m] = moving_d[m] ? period_s5[m] : '0;
						countdown_d[m] = reload_d[m];
						steps_d[m] = '0;
						coil_d[m] = moving_d[m] ? wave(neg_d[m], 2'd0) : '0;
					end
					limit_d = COUNT_BITS'(item_s5.cnt);
					active_d = |moving_d;
				end
			end
			CMD_STOP: begin
				active_d = 1'b0;
				coil_d = '0;
			end
			default: begin
				if (active_q) begin
					for (int m = 0; m < 2; m++) begin
						if (moving_q[m]) begin
							if (countdown_q[m] != '0) begin
								countdown_d[m] = countdown_q[m] - 1'b1;
							end
							if (countdown_d[m] == '0) begin
								expired[m] = 1'b1;
								steps_d[m] = steps_q[m] + 1'b1;
								if (limit_q != '0 && steps_d[m] == limit_q) begin
									finished = 1'b1;
								end
							end
						end
					end
					if (finished) begin
						active_d = 1'b0;
					end else begin
						for (int m = 0; m < 2; m++) begin
							if (expired[m]) begin
								coil_d[m] = wave(neg_q[m], steps_d[m][1:0]);
								countdown_d[m] = reload_q[m];
							end
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			status_q <= ST_OK;
			moving_q <= '0;
			neg_q <= '0;
			reload_q <= '0;
			countdown_q <= '0;
			steps_q <= '0;
			coil_q <= '0;
			limit_q <= '0;
			active_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_s5;
			if (v_s5) begin
				status_q <= item_s5.status;
				moving_q <= moving_d;
				neg_q <= neg_d;
				reload_q <= reload_d;
				countdown_q <= countdown_d;
				steps_q <= steps_d;
				coil_q <= coil_d;
				limit_q <= limit_d;
				active_q <= active_d;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign status = status_q;
	assign coils_left = coil_q[0];
	assign coils_right = coil_q[1];
	assign running = active_q;

endmodule

FILE: hdl/dual_stepper_differential_drive.sv
// Top level of the dual stepper differential drive controller: input register,
// period registers and flow control around dsdd_mix, dsdd_period and dsdd_motion.
// Uses dsdd_pkg.
//
// Each command transaction on the cmd channel (drive, rotate, stop or a
// one millisecond tick) yields exactly one result transaction on the res
// channel carrying the status, both coil patterns and the running flag.
// The two period registers are to be written by the user through cfg_we,
// cfg_index and cfg_wdata only while no transaction is in flight; the block
// itself does not enforce this. It is a six-register pipeline and takes
// one command transaction every cycle while res_stall does not hold a pending
// result; the motion state is updated only in the last stage, so commands act
// in order.
// Reset clears the pipeline, stops both motors, turns all coils off and
// loads the period registers with 5 and 50 ticks.
// While res_stall holds a pending result, the whole pipeline freezes and
// cmd_stall is raised in the same cycle; no transaction is lost.
module dual_stepper_differential_drive
	import dsdd_pkg::*;
#(
	parameter int PERIOD_BITS = PERIOD_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [CFG_BITS-1:0]          cfg_wdata,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [1:0]                   command,
	input  logic signed [SPEED_BITS-1:0] speed,
	input  logic signed [DIR_BITS-1:0]   direction,
	input  logic [STEP_BITS-1:0]         step_count,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [1:0]                   status,
	output logic [COIL_BITS-1:0]         coils_left,
	output logic [COIL_BITS-1:0]         coils_right,
	output logic                         running
);

	logic en;
	logic [PERIOD_BITS-1:0] min_period_q, max_period_q;

	logic v_s1;
	cmd_t cmd_s1;
	logic signed [SPEED_BITS-1:0] spd_s1;
	logic signed [DIR_BITS-1:0] dir_s1;
	logic [STEP_BITS-1:0] cnt_s1;

	logic v_s3, v_s5;
	item_t item_s3, item_s5;
	logic [1:0][PERIOD_BITS-1:0] period_s5;

	assign en = !res_valid || !res_stall;
	assign cmd_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= PERIOD_BITS'(MIN_PERIOD_RST);
			max_period_q <= PERIOD_BITS'(MAX_PERIOD_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_PERIOD: min_period_q <= PERIOD_BITS'(cfg_wdata);
				default: max_period_q <= PERIOD_BITS'(cfg_wdata);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_t'(command);
			spd_s1 <= speed;
			dir_s1 <= direction;
			cnt_s1 <= step_count;
		end
	end

	dsdd_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_s1    (v_s1),
		.cmd_s1  (cmd_s1),
		.spd_s1  (spd_s1),
		.dir_s1  (dir_s1),
		.cnt_s1  (cnt_s1),
		.v_s3    (v_s3),
		.item_s3 (item_s3)
	);

	dsdd_period #(
		.PERIOD_BITS (PERIOD_BITS)
	) u_period (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.min_period (min_period_q),
		.max_period (max_period_q),
		.v_s3       (v_s3),
		.item_s3    (item_s3),
		.v_s5       (v_s5),
		.item_s5    (item_s5),
		.period_s5  (period_s5)
	);

	dsdd_motion #(
		.PERIOD_BITS (PERIOD_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_motion (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.v_s5        (v_s5),
		.item_s5     (item_s5),
		.period_s5   (period_s5),
		.res_valid   (res_valid),
		.status      (status),
		.coils_left  (coils_left),
		.coils_right (coils_right),
		.running     (running)
	);

endmodule

FILE: test/dual_stepper_differential_drive_test.sv
// Testbench for dual_stepper_differential_drive: directed and random commands and ticks,
// checked against a behavioral model of the mixer, periods and wave stepping.
// Depends on dsdd_pkg and the RTL under hdl.
module dual_stepper_differential_drive_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dsdd_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	typedef struct packed {
		status_t              status;
		logic [COIL_BITS-1:0] coils_left;
		logic [COIL_BITS-1:0] coils_right;
		logic                 running;
	} drive_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic                         cfg_index = 1'b0;
	logic [CFG_BITS-1:0]          cfg_wdata = '0;
	logic                         cmd_valid = 1'b0;
	logic                         cmd_stall;
	logic [1:0]                   command = CMD_STOP;
	logic signed [SPEED_BITS-1:0] speed = '0;
	logic signed [DIR_BITS-1:0]   direction = '0;
	logic [STEP_BITS-1:0]         step_count = '0;
	logic                         res_valid;
	logic                         res_stall = 1'b0;
	logic [1:0]                   status;
	logic [COIL_BITS-1:0]         coils_left;
	logic [COIL_BITS-1:0]         coils_right;
	logic                         running;

	dual_stepper_differential_drive uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.speed(speed),
		.direction(direction),
		.step_count(step_count),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.coils_left(coils_left),
		.coils_right(coils_right),
		.running(running)
	);

	// Model of the motion state.
	int unsigned          min_ticks = MIN_PERIOD_RST;
	int unsigned          max_ticks = MAX_PERIOD_RST;
	int                   wheel_speed [2] = '{0, 0};
	int unsigned          reload [2] = '{0, 0};
	int unsigned          countdown [2] = '{0, 0};
	logic [STEP_BITS-1:0] steps_made [2] = '{'0, '0};
	logic [COIL_BITS-1:0] coil [2] = '{'0, '0};
	logic [STEP_BITS-1:0] stop_after = '0;
	bit                   moving = 1'b0;

	drive_result_t expected_results [$];
	drive_result_t got, want;
	int            mismatches = 0;
	int            items_sent = 0;
	int            send_gap_pct = 0;
	int            recv_stall_pct = 0;
	int            quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [COIL_BITS-1:0] coil_phase(int spd, logic [STEP_BITS-1:0] k);
		logic [1:0] ph;
		ph = k[1:0];
		if (spd < 0) begin
			ph = 2'd3 - ph;
		end
		case (ph)
			2'd0: return 4'b1000;
			2'd1: return 4'b0010;
			2'd2: return 4'b0100;
			default: return 4'b0001;
		endcase
	endfunction

	function automatic int unsigned step_period(int spd);
		int unsigned mag, lo, hi, p;
		mag = (spd < 0) ? -spd : spd;
		if (mag > PCT_FULL) begin
			mag = PCT_FULL;
		end
		lo = min_ticks;
		hi = (max_ticks < lo) ? lo : max_ticks;
		p = (lo + ((hi - lo) * (PCT_FULL - mag)) / PCT_FULL) & 32'h3FF;
		if (p == 0) begin
			p = 1;
		end
		return p;
	endfunction

	function automatic void begin_motion(int left, int right, logic [STEP_BITS-1:0] lim);
		wheel_speed[0] = left;
		wheel_speed[1] = right;
		stop_after = lim;
		moving = 1'b0;
		for (int m = 0; m < 2; m++) begin
			steps_made[m] = '0;
			coil[m] = '0;
			reload[m] = 0;
			countdown[m] = 0;
			if (wheel_speed[m] != 0) begin
				reload[m] = step_period(wheel_speed[m]);
				countdown[m] = reload[m];
				coil[m] = coil_phase(wheel_speed[m], '0);
				moving = 1'b1;
			end
		end
	endfunction

	function automatic void advance_tick();
		bit [1:0] expired;
		bit done;
		expired = '0;
		done = 1'b0;
		if (!moving) begin
			return;
		end
		for (int m = 0; m < 2; m++) begin
			if (wheel_speed[m] != 0) begin
				if (countdown[m] > 0) begin
					countdown[m]--;
				end
				if (countdown[m] == 0) begin
					expired[m] = 1'b1;
					steps_made[m] = steps_made[m] + 1'b1;
					if (stop_after != 0 && steps_made[m] == stop_after) begin
						done = 1'b1;
					end
				end
			end
		end
		if (done) begin
			moving = 1'b0;
			return;
		end
		for (int m = 0; m < 2; m++) begin
			if (expired[m]) begin
				coil[m] = coil_phase(wheel_speed[m], steps_made[m]);
				countdown[m] = reload[m];
			end
		end
	endfunction

	function automatic drive_result_t predict_command(cmd_t c, logic signed [SPEED_BITS-1:0] s,
			logic signed [DIR_BITS-1:0] d, logic [STEP_BITS-1:0] n);
		int spd, dir;
		status_t st;
		spd = s;
		dir = d;
		st = ST_OK;
		case (c)
			CMD_DRIVE, CMD_ROTATE: begin
				if (spd > PCT_FULL || spd < -PCT_FULL) begin
					st = ST_SPEED;
				end else if (c == CMD_DRIVE) begin
					if (dir > PCT_FULL || dir < -PCT_FULL) begin
						st = ST_DIR;
					end else if (dir < 0) begin
						begin_motion((spd * (PCT_FULL + dir)) / PCT_FULL, spd, n);
					end else if (dir > 0) begin
						begin_motion(spd, (spd * (PCT_FULL - dir)) / PCT_FULL, n);
					end else begin
						begin_motion(spd, spd, n);
					end
				end else if (dir == ROT_QUARTER || dir == -ROT_QUARTER
						|| dir == ROT_HALF || dir == -ROT_HALF) begin
					begin_motion(spd, -spd, n);
				end else begin
					st = ST_DIR;
				end
			end
			CMD_STOP: begin
				moving = 1'b0;
				coil[0] = '0;
				coil[1] = '0;
			end
			default: advance_tick();
		endcase
		return '{st, coil[0], coil[1], moving};
	endfunction

	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			got = '{status_t'(status), coils_left, coils_right, running};
			if (expected_results.size() == 0) begin
				$error("result transaction with no command outstanding");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatches++;
				end
				if (got.coils_left !== want.coils_left) begin
					$error("coils_left: expected %b, got %b", want.coils_left, got.coils_left);
					mismatches++;
				end
				if (got.coils_right !== want.coils_right) begin
					$error("coils_right: expected %b, got %b", want.coils_right,
						got.coils_right);
					mismatches++;
				end
				if (got.running !== want.running) begin
					$error("running: expected %0d, got %0d", want.running, got.running);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_command(cmd_t c, logic signed [SPEED_BITS-1:0] s,
			logic signed [DIR_BITS-1:0] d, logic [STEP_BITS-1:0] n);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		speed <= s;
		direction <= d;
		step_count <= n;
		@(posedge clk);
		while (cmd_stall) begin
			@(posedge clk);
		end
		expected_results.push_back(predict_command(c, s, d, n));
		items_sent++;
	endtask

	task automatic send_tick();
		send_command(CMD_TICK, SPEED_BITS'($urandom), DIR_BITS'($urandom),
			STEP_BITS'($urandom));
	endtask

	task automatic send_ticks(int count);
		repeat (count) begin
			send_tick();
		end
	endtask

	task automatic wait_results_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Call only with the block idle.
	task automatic set_periods(logic [CFG_BITS-1:0] lo, logic [CFG_BITS-1:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_PERIOD;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= REG_MAX_PERIOD;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_ticks = lo;
		max_ticks = hi;
	endtask

	task automatic test_idle_after_reset();
		send_tick();
		send_command(CMD_STOP, '0, '0, '0);
	endtask

	task automatic test_command_cases();
		send_command(CMD_DRIVE, 100, 0, 0);
		send_tick();
		send_command(CMD_DRIVE, -100, -100, 3);
		send_command(CMD_DRIVE, 127, 0, 0);
		send_command(CMD_DRIVE, -128, 0, 0);
		send_command(CMD_ROTATE, 101, 90, 0);
		send_command(CMD_ROTATE, -101, -256, 0);
		send_command(CMD_DRIVE, 50, 101, 0);
		send_command(CMD_DRIVE, 50, -101, 0);
		send_command(CMD_DRIVE, 50, 255, 0);
		send_command(CMD_DRIVE, 37, 55, 0);
		send_command(CMD_DRIVE, -37, -55, 0);
		send_command(CMD_DRIVE, 1, 100, 0);
		send_command(CMD_ROTATE, 60, 90, 4);
		send_command(CMD_ROTATE, -60, -90, 4);
		send_command(CMD_ROTATE, 100, 180, 0);
		send_command(CMD_ROTATE, -100, -180, 16'hFFFF);
		send_command(CMD_ROTATE, 60, 45, 0);
		send_command(CMD_ROTATE, 60, 0, 0);
		send_command(CMD_ROTATE, 0, 90, 0);
		send_command(CMD_DRIVE, 0, 0, 0);
		send_command(CMD_DRIVE, 80, 0, 0);
		send_command(CMD_STOP, '0, '0, '0);
		send_tick();
	endtask

	task automatic test_period_extremes();
		wait_results_drained();
		set_periods(1, 1);
		send_command(CMD_DRIVE, 100, 0, 2);
		send_ticks(3);
		wait_results_drained();
		set_periods(0, 0);
		send_command(CMD_DRIVE, -50, 0, 0);
		send_ticks(2);
		wait_results_drained();
		set_periods(300, 7);
		send_command(CMD_DRIVE, 100, 50, 0);
		send_tick();
		wait_results_drained();
		set_periods(1023, 1023);
		send_command(CMD_DRIVE, -1, 0, 0);
		send_tick();
		wait_results_drained();
		set_periods(2, 9);
		send_command(CMD_DRIVE, 100, 60, 3);
		send_ticks(7);
		wait_results_drained();
		set_periods(0, 1023);
		send_command(CMD_DRIVE, 100, 0, 0);
		send_command(CMD_DRIVE, 1, 0, 0);
		send_tick();
		wait_results_drained();
		set_periods(CFG_BITS'(MIN_PERIOD_RST), CFG_BITS'(MAX_PERIOD_RST));
	endtask

	task automatic pick_periods();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			set_periods(CFG_BITS'($urandom_range(1, 3)), CFG_BITS'($urandom_range(0, 8)));
		end else if (pick < 90) begin
			set_periods(CFG_BITS'($urandom_range(0, 2)), CFG_BITS'($urandom_range(0, 2)));
		end else begin
			set_periods(CFG_BITS'($urandom), CFG_BITS'($urandom));
		end
	endtask

	task automatic send_motion_command();
		int pick, spd, dir;
		logic [STEP_BITS-1:0] n;
		cmd_t c;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			spd = (pick < 8) ? PCT_FULL : -PCT_FULL;
		end else begin
			spd = int'($urandom_range(0, 200)) - PCT_FULL;
		end
		c = $urandom_range(0, 1) ? CMD_ROTATE : CMD_DRIVE;
		if (c == CMD_DRIVE) begin
			dir = int'($urandom_range(0, 200)) - PCT_FULL;
		end else begin
			case ($urandom_range(0, 3))
				0: dir = ROT_QUARTER;
				1: dir = -ROT_QUARTER;
				2: dir = ROT_HALF;
				default: dir = -ROT_HALF;
			endcase
		end
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			n = STEP_BITS'($urandom_range(1, 6));
		end else if (pick < 90) begin
			n = '0;
		end else begin
			n = STEP_BITS'($urandom);
		end
		send_command(c, SPEED_BITS'(spd), DIR_BITS'(dir), n);
	endtask

	task automatic test_random_motion(int gap_pct, int stall_pct, int count);
		int target, pick;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				wait_results_drained();
				pick_periods();
			end else if (pick < 14) begin
				wait_results_drained();
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_motion_command();
			end else if (pick < 85) begin
				send_command(cmd_t'($urandom_range(0, 3)), SPEED_BITS'($urandom),
					DIR_BITS'($urandom), STEP_BITS'($urandom));
			end else begin
				send_command(CMD_STOP, SPEED_BITS'($urandom), DIR_BITS'($urandom),
					STEP_BITS'($urandom));
			end
			send_ticks($urandom_range(0, 30));
		end
	endtask

	initial begin
		send_gap_pct = 18;
		recv_stall_pct = 85;
		repeat (12) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_after_reset();
		test_command_cases();
		test_period_extremes();
		test_random_motion(18, 85, 300);
		test_random_motion(85, 18, 300);
		test_random_motion(0, 0, 300);
		wait_results_drained();
		repeat (10) begin
			@(posedge clk);
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
